[rtl/acpc_pkg.sv]
// Types, constants and the BCD increment helper for the alarm clock panel controller.
// Depends on nothing; used by acpc_core and alarm_clock_panel_controller.
package acpc_pkg;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_BLANK_DIGIT_CODE = 1'b0,
      CSR_ALARM_VIEW_HOLD  = 1'b1
   } csr_index_type;

   localparam logic [3:0] BLANK_DIGIT_RESET = 4'd15;
   localparam logic [2:0] VIEW_HOLD_RESET   = 3'd7;

   localparam logic [5:0] DOTS_ALARM_VIEW = 6'b001010;
   localparam logic [5:0] DOTS_NONE       = 6'b000000;

   localparam logic [7:0] MINUTE_LIMIT = 8'd59;
   localparam logic [7:0] HOUR_LIMIT   = 8'd23;

   // Night dimming thresholds, compared against the BCD hour byte.
   localparam logic [7:0] DIM_FULL_LAST   = 8'h04;
   localparam logic [7:0] DIM_HALF_FIRST  = 8'h22;
   localparam logic [7:0] DIM_HALF_LAST   = 8'h05;
   localparam logic [7:0] DIM_LIGHT_FIRST = 8'h20;
   localparam logic [7:0] DIM_LIGHT_LAST  = 8'h06;

   localparam logic [2:0] DIM_LEVEL_NONE  = 3'd0;
   localparam logic [2:0] DIM_LEVEL_LIGHT = 3'd1;
   localparam logic [2:0] DIM_LEVEL_HALF  = 3'd2;
   localparam logic [2:0] DIM_LEVEL_FULL  = 3'd4;

   typedef struct packed {
      logic [3:0] blank_digit_code;
      logic [2:0] alarm_view_hold;
   } cfg_type;

   typedef struct packed {
      logic [5:0] rtc_hour;
      logic [6:0] rtc_minute;
      logic [6:0] rtc_second;
      logic       alarm_switch_on;
      logic       reset_pressed;
      logic       minute_pressed;
      logic       hour_pressed;
      logic       dimmer_switch_on;
      logic       second_pulse_level;
      logic       refresh_event;
      logic       half_second_tick;
   } poll_type;

   typedef struct packed {
      logic        refresh_pending;
      logic        alarm_view;
      logic        hold_timer_running;
      logic [2:0]  hold_count;
      logic        button_lock;
      logic        last_switch;
      logic        alarm_active;
      logic [23:0] shown_time;
      logic [23:0] set_time_buffer;
      logic [15:0] alarm_setting;
   } state_type;

   typedef struct packed {
      logic        display_update;
      logic [23:0] display_digits;
      logic [5:0]  dot_mask;
      logic        alarm_sounding;
      logic [2:0]  dimmer_level;
      logic        time_write;
      logic [23:0] time_write_value;
      logic        alarm_write;
      logic [15:0] alarm_time_value;
   } result_type;

   // Advances a packed BCD pair by one, wrapping to zero at or above the limit.
   // The pair is read as tens*10+units, so malformed digits still give a defined value.
   function automatic logic [7:0] bcd_step(input logic [7:0] bcd, input logic [7:0] limit);
      logic [7:0] v;
      logic [3:0] tens;
      logic [7:0] units;
      v = {1'b0, bcd[7:4], 3'b000} + {3'b000, bcd[7:4], 1'b0} + {4'b0000, bcd[3:0]};
      if (v >= limit) begin
         v = 8'd0;
      end else begin
         v = v + 8'd1;
      end
      priority if (v >= 8'd50) begin
         tens = 4'd5;
      end else if (v >= 8'd40) begin
         tens = 4'd4;
      end else if (v >= 8'd30) begin
         tens = 4'd3;
      end else if (v >= 8'd20) begin
         tens = 4'd2;
      end else if (v >= 8'd10) begin
         tens = 4'd1;
      end else begin
         tens = 4'd0;
      end
      units = v - ({1'b0, tens, 3'b000} + {3'b000, tens, 1'b0});
      return {tens, units[3:0]};
   endfunction

endpackage

[rtl/acpc_core.sv]
// Next-state and result logic for one panel poll.
// Depends on acpc_pkg; instantiated by alarm_clock_panel_controller.
module acpc_core (
   input  acpc_pkg::cfg_type    cfg,
   input  acpc_pkg::state_type  state_cur,
   input  acpc_pkg::poll_type   poll,
   output acpc_pkg::state_type  state_nxt,
   output acpc_pkg::result_type result
);

   always_comb begin
      acpc_pkg::state_type  s;
      acpc_pkg::result_type r;
      logic                 any_button;
      logic [7:0]           hour_byte;

      s          = state_cur;
      r          = '0;
      any_button = poll.reset_pressed || poll.minute_pressed || poll.hour_pressed;

      // Events come first.
      if (poll.refresh_event) begin
         s.refresh_pending = 1'b1;
      end
      if (poll.half_second_tick && s.hold_timer_running) begin
         if (s.hold_count == cfg.alarm_view_hold) begin
            s.alarm_view         = 1'b0;
            s.hold_timer_running = 1'b0;
            s.hold_count         = 3'd0;
         end else begin
            s.hold_count = s.hold_count + 3'd1;
         end
      end

      // Display.
      if (s.refresh_pending) begin
         if (s.alarm_view) begin
            r.dot_mask       = poll.second_pulse_level ? acpc_pkg::DOTS_ALARM_VIEW
                                                       : acpc_pkg::DOTS_NONE;
            r.display_digits = {cfg.blank_digit_code, cfg.blank_digit_code,
                                s.alarm_setting[3:0], s.alarm_setting[7:4],
                                s.alarm_setting[11:8], s.alarm_setting[15:12]};
         end else begin
            s.shown_time      = {2'b00, poll.rtc_hour, 1'b0, poll.rtc_minute,
                                 1'b0, poll.rtc_second};
            s.set_time_buffer = s.shown_time;
            r.dot_mask        = acpc_pkg::DOTS_NONE;
            // Hour tens sits in the lowest nibble of the digit word.
            for (int k = 0; k < 6; k++) begin
               r.display_digits[4*k +: 4] = s.shown_time[20 - 4*k +: 4];
            end
         end
         r.display_update  = 1'b1;
         s.refresh_pending = 1'b0;
      end

      // Switch and buttons.
      if (poll.alarm_switch_on) begin
         if (!s.last_switch) begin
            s.hold_timer_running = 1'b1;
            s.refresh_pending    = 1'b1;
            s.alarm_view         = 1'b1;
         end
         if (s.alarm_setting == s.shown_time[23:8] && s.shown_time[7:0] == 8'd0
             && !s.alarm_view) begin
            s.alarm_active = 1'b1;
         end
         if (!s.button_lock && any_button) begin
            s.hold_timer_running = 1'b1;
            s.refresh_pending    = 1'b1;
            s.alarm_view         = 1'b1;
            s.button_lock        = 1'b1;
            if (!poll.reset_pressed) begin
               if (poll.minute_pressed) begin
                  s.alarm_setting[7:0] = acpc_pkg::bcd_step(s.alarm_setting[7:0],
                                                            acpc_pkg::MINUTE_LIMIT);
               end else begin
                  s.alarm_setting[15:8] = acpc_pkg::bcd_step(s.alarm_setting[15:8],
                                                             acpc_pkg::HOUR_LIMIT);
               end
               r.alarm_write      = 1'b1;
               r.alarm_time_value = s.alarm_setting;
            end
         end
      end else begin
         if (s.last_switch) begin
            s.alarm_active = 1'b0;
         end
         if (!s.button_lock && any_button) begin
            s.refresh_pending = 1'b1;
            s.button_lock     = 1'b1;
            priority if (poll.reset_pressed) begin
               s.set_time_buffer[7:0] = 8'd0;
            end else if (poll.minute_pressed) begin
               s.set_time_buffer[15:8] = acpc_pkg::bcd_step(s.set_time_buffer[15:8],
                                                            acpc_pkg::MINUTE_LIMIT);
            end else begin
               s.set_time_buffer[23:16] = acpc_pkg::bcd_step(s.set_time_buffer[23:16],
                                                             acpc_pkg::HOUR_LIMIT);
            end
            r.time_write       = 1'b1;
            r.time_write_value = s.set_time_buffer;
         end
      end
      if (!any_button) begin
         s.button_lock = 1'b0;
      end

      // Dimmer level from the hour now on show.
      hour_byte = s.shown_time[23:16];
      priority if (poll.dimmer_switch_on && hour_byte <= acpc_pkg::DIM_FULL_LAST) begin
         r.dimmer_level = acpc_pkg::DIM_LEVEL_FULL;
      end else if (poll.dimmer_switch_on && (hour_byte >= acpc_pkg::DIM_HALF_FIRST
                                             || hour_byte <= acpc_pkg::DIM_HALF_LAST)) begin
         r.dimmer_level = acpc_pkg::DIM_LEVEL_HALF;
      end else if (poll.dimmer_switch_on && (hour_byte >= acpc_pkg::DIM_LIGHT_FIRST
                                             || hour_byte <= acpc_pkg::DIM_LIGHT_LAST)) begin
         r.dimmer_level = acpc_pkg::DIM_LEVEL_LIGHT;
      end else begin
         r.dimmer_level = acpc_pkg::DIM_LEVEL_NONE;
      end

      s.last_switch    = poll.alarm_switch_on;
      r.alarm_sounding = s.alarm_active;

      state_nxt = s;
      result    = r;
   end

endmodule

[rtl/alarm_clock_panel_controller.sv]
// Top level of the alarm clock panel controller: handshakes, state and result registers.
// Depends on acpc_pkg and acpc_core.
//
// Each accepted poll produces exactly one result word, registered and presented in the
// cycle after acceptance. A poll is taken in every cycle in which the result register
// is empty or its contents are being taken at the same edge, so the block sustains one
// poll per clock; the single pass through acpc_core between the panel state registers
// and the result register sets that figure. The two configuration registers are written
// through the csr_ port, which is always ready, and should only be written while no
// result is outstanding.
module alarm_clock_panel_controller (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [3:0]  csr_data,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [5:0]  req_rtc_hour,
   input  logic [6:0]  req_rtc_minute,
   input  logic [6:0]  req_rtc_second,
   input  logic        req_alarm_switch_on,
   input  logic        req_reset_pressed,
   input  logic        req_minute_pressed,
   input  logic        req_hour_pressed,
   input  logic        req_dimmer_switch_on,
   input  logic        req_second_pulse_level,
   input  logic        req_refresh_event,
   input  logic        req_half_second_tick,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_display_update,
   output logic [23:0] rsp_display_digits,
   output logic [5:0]  rsp_dot_mask,
   output logic        rsp_alarm_sounding,
   output logic [2:0]  rsp_dimmer_level,
   output logic        rsp_time_write,
   output logic [23:0] rsp_time_write_value,
   output logic        rsp_alarm_write,
   output logic [15:0] rsp_alarm_time_value
);

   acpc_pkg::cfg_type    cfg_ff, cfg_in;
   acpc_pkg::state_type  state_ff, state_in;
   acpc_pkg::result_type result_ff, result_in;
   acpc_pkg::poll_type   poll;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 req_accept;

   assign csr_ready  = 1'b1;
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   assign poll = '{
      rtc_hour:           req_rtc_hour,
      rtc_minute:         req_rtc_minute,
      rtc_second:         req_rtc_second,
      alarm_switch_on:    req_alarm_switch_on,
      reset_pressed:      req_reset_pressed,
      minute_pressed:     req_minute_pressed,
      hour_pressed:       req_hour_pressed,
      dimmer_switch_on:   req_dimmer_switch_on,
      second_pulse_level: req_second_pulse_level,
      refresh_event:      req_refresh_event,
      half_second_tick:   req_half_second_tick
   };

   acpc_core u_core (
      .cfg       (cfg_ff),
      .state_cur (state_ff),
      .poll      (poll),
      .state_nxt (state_in),
      .result    (result_in)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            acpc_pkg::CSR_BLANK_DIGIT_CODE: cfg_in.blank_digit_code = csr_data;
            acpc_pkg::CSR_ALARM_VIEW_HOLD:  cfg_in.alarm_view_hold  = csr_data[2:0];
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blank_digit_code <= acpc_pkg::BLANK_DIGIT_RESET;
         cfg_ff.alarm_view_hold  <= acpc_pkg::VIEW_HOLD_RESET;
         state_ff                <= '0;
         rsp_valid_ff            <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            state_ff <= state_in;
         end
      end
   end

   // The result word carries no reset; rsp_valid qualifies it.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_display_update   = result_ff.display_update;
   assign rsp_display_digits   = result_ff.display_digits;
   assign rsp_dot_mask         = result_ff.dot_mask;
   assign rsp_alarm_sounding   = result_ff.alarm_sounding;
   assign rsp_dimmer_level     = result_ff.dimmer_level;
   assign rsp_time_write       = result_ff.time_write;
   assign rsp_time_write_value = result_ff.time_write_value;
   assign rsp_alarm_write      = result_ff.alarm_write;
   assign rsp_alarm_time_value = result_ff.alarm_time_value;

endmodule
